/* hw/rtl/rsba_pkg.sv */
// shared types, constants and helpers for the refcounted segment bump allocator
// no dependencies; compiled first
package rsba_pkg;

  localparam int NumSegments  = 64;
  localparam int PageBytes    = 4096;
  localparam int PageLog2     = $clog2(PageBytes);

  localparam int SegW         = $clog2(NumSegments);
  localparam int PoolW        = $clog2(NumSegments + 1);
  localparam int SegsInUseW   = 7;
  localparam int OffW         = 31;
  localparam int CntW         = 32;
  localparam int ReqW         = 32;
  localparam int SizeW        = ReqW + 1;
  localparam int PagesW       = ReqW - PageLog2 + 1;
  localparam int OpW          = 2;
  localparam int StatusW      = 2;
  localparam int CfgIdxW      = 1;
  localparam int CfgDataW     = 31;

  localparam logic [OffW-1:0]       SegBytesReset  = OffW'(2097152);
  localparam logic [SegsInUseW-1:0] SegsInUseReset = SegsInUseW'(64);
  localparam logic [CntW-1:0]       CntMax         = '1;

  typedef enum logic [OpW-1:0] {
    OP_ALLOC    = 2'd0,
    OP_ADD_REF  = 2'd1,
    OP_DROP_REF = 2'd2,
    OP_RSVD     = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK   = 2'd0,
    ST_BUSY = 2'd1,
    ST_BIG  = 2'd2,
    ST_REF  = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SEG_BYTES   = 1'b0,
    CFG_SEGS_IN_USE = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CLS_ALLOC,
    CLS_ADD,
    CLS_DROP,
    CLS_FAIL
  } cls_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EVAL,
    BK_RETRY
  } back_state_e;

  // classified request handed from the front part to the back part
  typedef struct packed {
    cls_e             cls;
    status_e          fail_st;
    logic [SegW-1:0]  target;
    logic [SizeW-1:0] size;
  } cmd_t;

  typedef struct packed {
    logic            found;
    logic [SegW-1:0] idx;
  } seg_sel_t;

  // lowest set bit
  function automatic seg_sel_t first_set(logic [NumSegments-1:0] v);
    seg_sel_t r;
    r = '0;
    for (int i = NumSegments - 1; i >= 0; i--) begin
      if (v[i]) begin
        r.found = 1'b1;
        r.idx   = SegW'(i);
      end
    end
    return r;
  endfunction

endpackage

/* hw/rtl/rsba_if.sv */
// request and response channel interfaces for the allocator
// depends on rsba_pkg
interface rsba_req_if;
  logic                          valid;
  logic                          ready;
  logic [rsba_pkg::OpW-1:0]      operation;
  logic [rsba_pkg::ReqW-1:0]     request_bytes;
  logic [rsba_pkg::SegW-1:0]     target_segment;

  modport source (output valid, operation, request_bytes, target_segment, input ready);
  modport sink   (input valid, operation, request_bytes, target_segment, output ready);
endinterface

interface rsba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [rsba_pkg::StatusW-1:0]  status;
  logic [rsba_pkg::SegW-1:0]     granted_segment;
  logic [rsba_pkg::OffW-1:0]     byte_offset;

  modport source (output valid, status, granted_segment, byte_offset, input ready);
  modport sink   (input valid, status, granted_segment, byte_offset, output ready);
endinterface

/* hw/rtl/rsba_ram.sv */
// generic single write port, single read port ram with registered read data
// no dependencies
module rsba_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/rsba_front.sv */
// front part: takes requests, rounds sizes, flags bad requests, two-entry queue
// depends on rsba_pkg and rsba_if
module rsba_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  rsba_req_if.sink                   req_i,
  input  logic [rsba_pkg::OffW-1:0]  seg_bytes_i,
  input  logic [rsba_pkg::PoolW-1:0] pool_n_i,
  output rsba_pkg::cmd_t             cmd_o,
  output logic                       cmd_valid_o,
  input  logic                       cmd_ready_i
);
  import rsba_pkg::*;

  cmd_t              cls_cmd;
  logic [PagesW-1:0] pages;
  logic [SizeW-1:0]  size;

  cmd_t       q_mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  // round up to whole pages
  always_comb begin
    pages = {1'b0, req_i.request_bytes[ReqW-1:PageLog2]}
          + PagesW'(|req_i.request_bytes[PageLog2-1:0]);
    size  = {pages, {PageLog2{1'b0}}};
  end

  always_comb begin
    cls_cmd         = '0;
    cls_cmd.target  = req_i.target_segment;
    cls_cmd.size    = size;
    cls_cmd.fail_st = ST_REF;
    case (op_e'(req_i.operation))
      OP_ALLOC: begin
        if (size > SizeW'(seg_bytes_i)) begin
          cls_cmd.cls     = CLS_FAIL;
          cls_cmd.fail_st = ST_BIG;
        end else begin
          cls_cmd.cls = CLS_ALLOC;
        end
      end
      OP_ADD_REF: begin
        cls_cmd.cls = (PoolW'(req_i.target_segment) >= pool_n_i) ? CLS_FAIL : CLS_ADD;
      end
      OP_DROP_REF: begin
        cls_cmd.cls = (PoolW'(req_i.target_segment) >= pool_n_i) ? CLS_FAIL : CLS_DROP;
      end
      default: begin
        cls_cmd.cls = CLS_FAIL;
      end
    endcase
  end

  assign req_i.ready = (count_q != 2'd2);
  assign push        = req_i.valid && req_i.ready;
  assign cmd_valid_o = (count_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cls_cmd;
    end
  end

endmodule

/* hw/rtl/rsba_back.sv */
// back part: offset and count memories, free segment search, result register
// depends on rsba_pkg, rsba_if and rsba_ram
module rsba_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rsba_pkg::cmd_t             cmd_i,
  input  logic                       cmd_valid_i,
  output logic                       cmd_ready_o,
  input  logic [rsba_pkg::OffW-1:0]  seg_bytes_i,
  input  logic [rsba_pkg::PoolW-1:0] pool_n_i,
  rsba_rsp_if.source                 rsp_o
);
  import rsba_pkg::*;

  back_state_e state_q, state_d;
  cmd_t        cmd_q, cmd_d;
  logic [SegW-1:0] cur_q, cur_d;
  logic [SegW-1:0] addr_q, addr_d;
  logic            same_q, same_d;

  logic [NumSegments-1:0] fval_q, cval_q, zero_q;

  logic            rsp_valid_q, rsp_valid_d;
  status_e         rsp_st_q, rsp_st_d;
  logic [SegW-1:0] rsp_seg_q, rsp_seg_d;
  logic [OffW-1:0] rsp_off_q, rsp_off_d;

  logic            fill_we, cnt_we, rd_en;
  logic [SegW-1:0] fill_wa, cnt_wa, rd_addr;
  logic [OffW-1:0] fill_wd, fill_rd, fill_cur;
  logic [CntW-1:0] cnt_wd, cnt_rd, cnt_cur;

  logic                   out_free, rsp_load, fits;
  logic [SizeW:0]         sum;
  logic [SegW-1:0]        cur_eff;
  logic [NumSegments-1:0] pool_mask, ge_mask, cand;
  seg_sel_t               sel_hi, sel_all, sel;

  rsba_ram #(.Width(OffW), .Depth(NumSegments)) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (fill_wa),
    .wdata_i (fill_wd),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (fill_rd)
  );

  rsba_ram #(.Width(CntW), .Depth(NumSegments)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_wa),
    .wdata_i (cnt_wd),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (cnt_rd)
  );

  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign cur_eff  = (PoolW'(cur_q) >= pool_n_i) ? '0 : cur_q;
  assign fill_cur = fval_q[addr_q] ? fill_rd : '0;
  assign cnt_cur  = cval_q[addr_q] ? cnt_rd : '0;
  assign sum      = (SizeW + 1)'(fill_cur) + (SizeW + 1)'(cmd_q.size);
  assign fits     = (fill_cur != seg_bytes_i) && (sum <= (SizeW + 1)'(seg_bytes_i));

  // circular search for a segment with no references, from the current one
  always_comb begin
    for (int i = 0; i < NumSegments; i++) begin
      pool_mask[i] = (PoolW'(i) < pool_n_i);
      ge_mask[i]   = (SegW'(i) >= addr_q);
    end
    cand    = zero_q & pool_mask;
    sel_hi  = first_set(cand & ge_mask);
    sel_all = first_set(cand);
    sel     = sel_hi.found ? sel_hi : sel_all;
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    cur_d       = cur_q;
    addr_d      = addr_q;
    same_d      = same_q;
    cmd_ready_o = 1'b0;
    fill_we     = 1'b0;
    fill_wa     = addr_q;
    fill_wd     = seg_bytes_i;
    cnt_we      = 1'b0;
    cnt_wa      = addr_q;
    cnt_wd      = cnt_cur;
    rd_en       = 1'b0;
    rd_addr     = addr_q;
    rsp_load    = 1'b0;
    rsp_st_d    = ST_OK;
    rsp_seg_d   = '0;
    rsp_off_d   = '0;

    case (state_q)
      BK_IDLE: begin
        cmd_ready_o = (cmd_i.cls != CLS_FAIL) || out_free;
        if (cmd_valid_i && cmd_ready_o) begin
          cmd_d = cmd_i;
          case (cmd_i.cls)
            CLS_FAIL: begin
              rsp_load = 1'b1;
              rsp_st_d = cmd_i.fail_st;
            end
            CLS_ALLOC: begin
              cur_d   = cur_eff;
              addr_d  = cur_eff;
              rd_en   = 1'b1;
              rd_addr = cur_eff;
              state_d = BK_EVAL;
            end
            default: begin
              addr_d  = cmd_i.target;
              rd_en   = 1'b1;
              rd_addr = cmd_i.target;
              state_d = BK_EVAL;
            end
          endcase
        end
      end

      BK_EVAL: begin
        case (cmd_q.cls)
          CLS_ADD: begin
            if (out_free) begin
              rsp_load = 1'b1;
              if (cnt_cur == '0 || cnt_cur == CntMax) begin
                rsp_st_d = ST_REF;
              end else begin
                cnt_we = 1'b1;
                cnt_wd = cnt_cur + CntW'(1);
              end
              state_d = BK_IDLE;
            end
          end
          CLS_DROP: begin
            if (out_free) begin
              rsp_load = 1'b1;
              if (cnt_cur == '0) begin
                rsp_st_d = ST_REF;
              end else begin
                cnt_we = 1'b1;
                cnt_wd = cnt_cur - CntW'(1);
                if (cnt_cur == CntW'(1)) begin
                  fill_we = 1'b1;
                  fill_wd = '0;
                end
              end
              state_d = BK_IDLE;
            end
          end
          CLS_ALLOC: begin
            if (fits) begin
              if (out_free) begin
                rsp_load = 1'b1;
                if (cnt_cur == CntMax) begin
                  rsp_st_d = ST_REF;
                end else begin
                  fill_we   = 1'b1;
                  fill_wd   = sum[OffW-1:0];
                  cnt_we    = 1'b1;
                  cnt_wd    = cnt_cur + CntW'(1);
                  rsp_seg_d = addr_q;
                  rsp_off_d = fill_cur;
                end
                state_d = BK_IDLE;
              end
            end else if (sel.found) begin
              // mark full and look again in the free segment
              fill_we = 1'b1;
              cur_d   = sel.idx;
              addr_d  = sel.idx;
              same_d  = (sel.idx == addr_q);
              rd_en   = 1'b1;
              rd_addr = sel.idx;
              state_d = BK_RETRY;
            end else if (out_free) begin
              fill_we  = 1'b1;
              rsp_load = 1'b1;
              rsp_st_d = ST_BUSY;
              state_d  = BK_IDLE;
            end
          end
          default: begin
            state_d = BK_IDLE;
          end
        endcase
      end

      BK_RETRY: begin
        if (out_free) begin
          rsp_load = 1'b1;
          if (!same_q && fits) begin
            fill_we   = 1'b1;
            fill_wd   = sum[OffW-1:0];
            cnt_we    = 1'b1;
            cnt_wd    = CntW'(1);
            rsp_seg_d = addr_q;
            rsp_off_d = fill_cur;
          end else begin
            fill_we  = !same_q;
            rsp_st_d = ST_BUSY;
          end
          state_d = BK_IDLE;
        end
      end

      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cur_q       <= '0;
      rsp_valid_q <= 1'b0;
      fval_q      <= '0;
      cval_q      <= '0;
      zero_q      <= '1;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      rsp_valid_q <= rsp_valid_d;
      if (fill_we) begin
        fval_q[fill_wa] <= 1'b1;
      end
      if (cnt_we) begin
        cval_q[cnt_wa] <= 1'b1;
        zero_q[cnt_wa] <= (cnt_wd == '0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    addr_q <= addr_d;
    same_q <= same_d;
    if (rsp_load) begin
      rsp_st_q  <= rsp_st_d;
      rsp_seg_q <= rsp_seg_d;
      rsp_off_q <= rsp_off_d;
    end
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.status          = rsp_st_q;
  assign rsp_o.granted_segment = rsp_seg_q;
  assign rsp_o.byte_offset     = rsp_off_q;

endmodule

/* hw/rtl/refcounted_segment_bump_allocator.sv */
// top level of the refcounted segment bump allocator: config registers, front and back parts
// depends on rsba_pkg, rsba_if, rsba_front and rsba_back
//
// Each request gives exactly one response. The front part rounds the size up to pages,
// rejects oversized allocations, bad reference requests and the reserved operation, and
// holds up to two requests in a registered queue; the back part works on one request at
// a time. An add or drop reference and an allocation that fits the current segment go
// through one registered read of the offset and count memories, then the update; an
// allocation that overflows its segment reads the free segment that the search finds
// before the update, and answers busy when it finds none. Requests rejected by the front
// part are answered without a memory read. Offsets and counts read as zero after reset
// through per-segment valid bits, so no clearing pass is needed.
module refcounted_segment_bump_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rsba_req_if.sink                      req_i,
  rsba_rsp_if.source                    rsp_o,
  input  logic                          cfg_we_i,
  input  logic [rsba_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rsba_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import rsba_pkg::*;

  logic [OffW-1:0]       seg_bytes_q;
  logic [SegsInUseW-1:0] segs_in_use_q;
  logic [PoolW-1:0]      pool_n;
  cmd_t                  cmd;
  logic                  cmd_valid, cmd_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_bytes_q   <= SegBytesReset;
      segs_in_use_q <= SegsInUseReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_SEG_BYTES:   seg_bytes_q   <= cfg_wdata_i[OffW-1:0];
        CFG_SEGS_IN_USE: segs_in_use_q <= cfg_wdata_i[SegsInUseW-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, anything above the built count as the built count
  always_comb begin
    if (segs_in_use_q == '0) begin
      pool_n = PoolW'(1);
    end else if (PoolW'(segs_in_use_q) > PoolW'(NumSegments)) begin
      pool_n = PoolW'(NumSegments);
    end else begin
      pool_n = PoolW'(segs_in_use_q);
    end
  end

  rsba_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .seg_bytes_i (seg_bytes_q),
    .pool_n_i    (pool_n),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready)
  );

  rsba_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .seg_bytes_i (seg_bytes_q),
    .pool_n_i    (pool_n),
    .rsp_o       (rsp_o)
  );

  a_fail_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status != ST_OK |->
      rsp_o.granted_segment == '0 && rsp_o.byte_offset == '0)
    else $error("failed response carries a segment or offset");

  a_grant_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status == ST_OK |-> PoolW'(rsp_o.granted_segment) < pool_n)
    else $error("granted segment outside the pool");

  a_queue_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> cmd_valid)
    else $error("accepted request missing from the queue");

endmodule
